>>> src/rgbc_pkg.sv
package rgbc_pkg;

  // One pixel in the line memories and the window: [2] red, [1] green, [0] blue.
  typedef logic [2:0][7:0] rgb_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       last_pixel;
  } pix_out_t;

  typedef enum logic [1:0] {
    MODE_BLUR    = 2'd0,
    MODE_SHARPEN = 2'd1,
    MODE_EDGE    = 2'd2,
    MODE_PASS    = 2'd3
  } mode_t;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  localparam int         CFG_W          = 11;
  localparam logic [10:0] WIDTH_RESET   = 11'd640;
  localparam logic [10:0] HEIGHT_RESET  = 11'd480;

  // Upper and middle line entries share one memory word.
  typedef struct packed {
    rgb_t upper;
    rgb_t middle;
  } line_pair_t;

  // 3x3 neighborhood, index row*3 + col, row 0 on top, col 0 oldest.
  typedef rgb_t [8:0] win_t;

  typedef struct packed {
    logic  valid;
    logic  last;
    mode_t mode;
  } kctl_t;

  // floor(x / 9) equals (x * 7282) >> 16 for every nine-tap sum (x < 2296).
  localparam logic [23:0] BLUR_RECIP = 24'd7282;
  localparam int          BLUR_SHIFT = 16;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CW    = 4;

  function automatic logic [7:0] clamp_u8(logic signed [12:0] s);
    logic [7:0] r;
    if (s < 13'sd0) begin
      r = 8'd0;
    end else if (s > 13'sd255) begin
      r = 8'd255;
    end else begin
      r = s[7:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] chan_result(logic [11:0] all, logic [9:0] nb4,
                                             logic [7:0] ctr, mode_t mode);
    logic [23:0]        prod;
    logic signed [12:0] s;
    prod = 24'(all) * BLUR_RECIP;
    case (mode)
      MODE_BLUR:    s = signed'({5'd0, prod[BLUR_SHIFT +: 8]});
      MODE_SHARPEN: s = signed'(13'(13'(ctr) * 13'd5) - 13'(nb4));
      MODE_EDGE:    s = signed'(13'(13'(ctr) * 13'd9) - 13'(all));
      default:      s = signed'(13'(ctr));
    endcase
    return clamp_u8(s);
  endfunction

endpackage

>>> src/rgb_convolution_3x3_core.sv
// 3x3 RGB convolution over a raster-order pixel stream.
// Pixels enter on pix / pix_valid / pix_stall, one transaction per pixel in
// raster order. Filtered pixels leave on res / res_valid / res_stall, one
// transaction per interior pixel; border pixels produce nothing. The result
// for center (r-1, c-1) is produced by pixel (r, c); last_pixel marks the
// final interior pixel of a frame.
// Throughput is one pixel per cycle while pix_stall is low. The pixel that
// completes a window passes the registered line-memory read, the per-channel
// sums and the kernel and clamp into the output queue before its result is
// offered.
// The line memory is one synchronous RAM, read for column c when the pixel
// arrives and written back in the following cycle, so consecutive pixels never
// touch the same entry. An 8-entry output queue absorbs receiver stalls;
// pix_stall rises once 8 results are pending.
// Reset sets width 640, height 480, blur mode and restarts the frame; the line
// memory holds no reset state. Writing width or height restarts the frame. The user
// must write configuration only while the block is idle; the block does not enforce it.
module rgb_convolution_3x3_core
  import rgbc_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pix_valid,
  output logic             pix_stall,
  input  pix_in_t          pix,
  output logic             res_valid,
  input  logic             res_stall,
  output pix_out_t         res,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  mode_t            filter_mode;

  logic [CW-1:0] col_cnt;
  logic [RW-1:0] row_cnt;
  logic [CW-1:0] last_col;
  logic [RW-1:0] last_row;
  logic [12:0]   wv;
  logic [12:0]   hv;

  logic          accept;
  logic          interior;

  logic          s1_valid;
  logic          s1_int;
  logic          s1_last;
  mode_t         s1_mode;
  rgb_t          s1_px;
  logic [CW-1:0] s1_addr;

  line_pair_t    rd_data;
  line_pair_t    wr_data;
  rgb_t          win [2][3];
  rgb_t          col [3];
  win_t          taps;
  kctl_t         kctl;

  logic          res_push;
  pix_out_t      res_new;
  logic [FIFO_CW-1:0] pending;
  logic          res_pop;

  // Effective frame size, saturated to 3..MAX.
  assign wv = 13'(image_width);
  assign hv = 13'(image_height);

  always_comb begin
    if (wv < 13'd3) begin
      last_col = CW'(2);
    end else if (wv > 13'(MAX_WIDTH)) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(wv - 13'd1);
    end
    if (hv < 13'd3) begin
      last_row = RW'(2);
    end else if (hv > 13'(MAX_HEIGHT)) begin
      last_row = RW'(MAX_HEIGHT - 1);
    end else begin
      last_row = RW'(hv - 13'd1);
    end
  end

  assign pix_stall = (pending >= FIFO_CW'(FIFO_DEPTH));
  assign accept    = pix_valid && !pix_stall;
  assign interior  = (row_cnt >= RW'(2)) && (col_cnt >= CW'(2));
  assign res_pop   = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      filter_mode  <= MODE_BLUR;
      col_cnt      <= '0;
      row_cnt      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH: begin
          image_width <= cfg_data;
          col_cnt     <= '0;
          row_cnt     <= '0;
        end
        REG_HEIGHT: begin
          image_height <= cfg_data;
          col_cnt      <= '0;
          row_cnt      <= '0;
        end
        REG_MODE: begin
          filter_mode <= mode_t'(cfg_data[1:0]);
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (col_cnt == last_col) begin
        col_cnt <= '0;
        row_cnt <= (row_cnt == last_row) ? '0 : row_cnt + RW'(1);
      end else begin
        col_cnt <= col_cnt + CW'(1);
      end
    end
  end

  // Results accepted but not yet delivered, for the queue credit.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({accept && interior, res_pop})
        2'b10:   pending <= pending + FIFO_CW'(1);
        2'b01:   pending <= pending - FIFO_CW'(1);
        default: pending <= pending;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px   <= {pix.red_in, pix.green_in, pix.blue_in};
      s1_addr <= col_cnt;
      s1_int  <= interior;
      s1_last <= (row_cnt == last_row) && (col_cnt == last_col);
      s1_mode <= filter_mode;
    end
  end

  rgbc_line_mem #(
    .DEPTH(MAX_WIDTH)
  ) u_line_mem (
    .clk    (clk),
    .rd_en  (accept),
    .rd_addr(col_cnt),
    .rd_data(rd_data),
    .wr_en  (s1_valid),
    .wr_addr(s1_addr),
    .wr_data(wr_data)
  );

  // The line memory shifts down one row: middle becomes upper, the pixel becomes middle.
  assign wr_data.upper  = rd_data.middle;
  assign wr_data.middle = s1_px;

  assign col[0] = rd_data.upper;
  assign col[1] = rd_data.middle;
  assign col[2] = s1_px;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      taps[r*3 + 0] = win[0][r];
      taps[r*3 + 1] = win[1][r];
      taps[r*3 + 2] = col[r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        win[0][r] <= '0;
        win[1][r] <= '0;
      end
    end else if (s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[0][r] <= win[1][r];
        win[1][r] <= col[r];
      end
    end
  end

  assign kctl.valid = s1_valid && s1_int;
  assign kctl.last  = s1_last;
  assign kctl.mode  = s1_mode;

  rgbc_kernel u_kernel (
    .clk     (clk),
    .rst     (rst),
    .ctl     (kctl),
    .taps    (taps),
    .res_push(res_push),
    .res     (res_new)
  );

  rgbc_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .push_data(res_new),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

  // The read for a new pixel never hits the entry being written back.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    !(accept && s1_valid && (col_cnt == s1_addr)))
    else $error("line memory read and write-back hit the same entry");

  // The credit counter never runs past the queue depth.
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= FIFO_CW'(FIFO_DEPTH))
    else $error("pending results exceed queue depth");

  // A result can only be offered while one is pending.
  a_valid_pending: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (pending != '0))
    else $error("result offered with nothing pending");

  // An interior pixel reaches the kernel the cycle after it is taken.
  a_interior_flow: assert property (@(posedge clk) disable iff (rst)
    (accept && interior) |=> kctl.valid)
    else $error("interior pixel lost before the kernel");

endmodule

>>> src/rgbc_line_mem.sv
module rgbc_line_mem
  import rgbc_pkg::*;
#(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output line_pair_t    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  line_pair_t    wr_data
);

  line_pair_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/rgbc_kernel.sv
module rgbc_kernel
  import rgbc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  kctl_t    ctl,
  input  win_t     taps,
  output logic     res_push,
  output pix_out_t res
);

  logic [2:0][11:0] all;
  logic [2:0][9:0]  nb4;
  logic [2:0][7:0]  ctr;
  logic             last;
  mode_t            mode;
  logic             valid;
  logic [2:0][7:0]  val;

  // First stage: nine-tap and four-neighbor sums per channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      last <= ctl.last;
      mode <= ctl.mode;
      for (int ch = 0; ch < 3; ch++) begin
        all[ch] <= 12'(taps[0][ch]) + 12'(taps[1][ch]) + 12'(taps[2][ch])
                 + 12'(taps[3][ch]) + 12'(taps[4][ch]) + 12'(taps[5][ch])
                 + 12'(taps[6][ch]) + 12'(taps[7][ch]) + 12'(taps[8][ch]);
        nb4[ch] <= 10'(taps[1][ch]) + 10'(taps[3][ch]) + 10'(taps[5][ch])
                 + 10'(taps[7][ch]);
        ctr[ch] <= taps[4][ch];
      end
    end
  end

  // Second stage: kernel weight, divide or clamp; the output queue registers it.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      val[ch] = chan_result(all[ch], nb4[ch], ctr[ch], mode);
    end
  end

  assign res_push       = valid;
  assign res.red_out    = val[2];
  assign res.green_out  = val[1];
  assign res.blue_out   = val[0];
  assign res.last_pixel = last;

endmodule

>>> src/rgbc_out_fifo.sv
module rgbc_out_fifo
  import rgbc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  pix_out_t push_data,
  output logic     res_valid,
  input  logic     res_stall,
  output pix_out_t res
);

  pix_out_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_CW-1:0]   count;
  logic                 pop;

  assign res_valid = (count != '0);
  assign res       = mem[rd_ptr];
  assign pop       = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + FIFO_CW'(1);
        2'b01:   count <= count - FIFO_CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rgbc_pkg::*;

  localparam int LINE_MAX = 1024;
  localparam int DIM_MIN = 3;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 120;
  localparam int PHASES = 24;
  localparam int PRESSURE_PHASE = 3;
  localparam int WIDE_PHASE = 20;
  localparam int LONG_WIDTH = 100;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             pix_valid = 1'b0;
  logic             pix_stall;
  pix_in_t          pix = '0;
  logic             res_valid;
  logic             res_stall = 1'b0;
  pix_out_t         res;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = REG_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  rgb_convolution_3x3_core dut (
    .clk(clk),
    .rst(rst),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix(pix),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the filter state, advanced once per accepted pixel.
  rgb_t             upper_row [LINE_MAX];
  rgb_t             middle_row [LINE_MAX];
  rgb_t             window_col [6];
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;
  logic [CFG_W-1:0] width_reg = WIDTH_RESET;
  logic [CFG_W-1:0] height_reg = HEIGHT_RESET;
  mode_t            mode_reg = MODE_BLUR;

  pix_out_t filtered_due [$];
  int       mismatches = 0;
  int       src_idle_pct = 27;
  int       dst_idle_pct = 64;
  int       phase_num = -1;
  int       hold_left = 0;
  bit       held_off = 1'b0;
  int       quiet_cycles = 0;

  typedef struct packed {
    bit               is_cfg;
    logic [1:0]       idx;
    logic [CFG_W-1:0] val;
    pix_in_t          p;
    bit               typed;
    pix_out_t         want;
  } plan_entry_t;

  plan_entry_t plan [$];

  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > LINE_MAX) return LINE_MAX;
    return v;
  endfunction

  // Taps are indexed row*3 + col, row 0 on top, col 0 oldest.
  function automatic logic [7:0] apply_kernel(logic [8:0][7:0] t, mode_t m);
    int all_sum;
    int cross_sum;
    int ctr;
    int s;
    int i;
    all_sum = 0;
    for (i = 0; i < 9; i++) all_sum += t[i];
    ctr = t[4];
    cross_sum = t[1] + t[3] + t[5] + t[7];
    case (m)
      MODE_BLUR:    s = all_sum / 9;
      MODE_SHARPEN: s = 5 * ctr - cross_sum;
      MODE_EDGE:    s = 8 * ctr - (all_sum - ctr);
      default:      s = ctr;
    endcase
    if (s < 0) begin
      s = 0;
    end else if (s > 255) begin
      s = 255;
    end
    return s[7:0];
  endfunction

  task automatic filter_pixel(input pix_in_t p, output bit produced, output pix_out_t y);
    int unsigned     w;
    int unsigned     h;
    int unsigned     k;
    rgb_t            px;
    rgb_t            up;
    rgb_t            mid;
    logic [8:0][7:0] t;
    logic [2:0][7:0] ch;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    px = {p.red_in, p.green_in, p.blue_in};
    up = upper_row[col_pos];
    mid = middle_row[col_pos];
    for (k = 0; k < 3; k++) begin
      t[0] = window_col[0][k];
      t[1] = window_col[3][k];
      t[2] = up[k];
      t[3] = window_col[1][k];
      t[4] = window_col[4][k];
      t[5] = mid[k];
      t[6] = window_col[2][k];
      t[7] = window_col[5][k];
      t[8] = px[k];
      ch[k] = apply_kernel(t, mode_reg);
    end
    produced = (row_pos >= 2 && col_pos >= 2);
    y = {ch[2], ch[1], ch[0], (row_pos == h - 1 && col_pos == w - 1)};

    for (k = 0; k < 3; k++) window_col[k] = window_col[k + 3];
    window_col[3] = up;
    window_col[4] = mid;
    window_col[5] = px;
    upper_row[col_pos] = mid;
    middle_row[col_pos] = px;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WIDTH: begin
        width_reg = val;
        col_pos = 0;
        row_pos = 0;
      end
      REG_HEIGHT: begin
        height_reg = val;
        col_pos = 0;
        row_pos = 0;
      end
      REG_MODE: begin
        mode_reg = mode_t'(val[1:0]);
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Border pixels give no result, so one may still be in flight once the
  // pending queue is empty; the extra cycles cover the pipeline.
  task automatic settle();
    pix_valid <= 1'b0;
    while (filtered_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_pixel(input pix_in_t p, input bit typed, input pix_out_t want);
    bit       produced;
    pix_out_t y;
    while ($urandom_range(99, 0) < src_idle_pct) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix <= p;
    do @(posedge clk); while (pix_stall);
    filter_pixel(p, produced, y);
    if (typed) begin
      filtered_due.push_back(want);
    end else if (produced) begin
      filtered_due.push_back(y);
    end
  endtask

  function automatic logic [7:0] random_level();
    case ($urandom_range(5, 0))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255, 0));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_width();
    if ($urandom_range(7, 0) == 0) return CFG_W'($urandom_range(2, 0));
    return CFG_W'($urandom_range(10, 3));
  endfunction

  // Tall frames cost little since only their first rows are streamed.
  function automatic logic [CFG_W-1:0] pick_height();
    case ($urandom_range(9, 0))
      0:       return CFG_W'($urandom_range(2, 0));
      1:       return CFG_W'(LINE_MAX);
      2:       return '1;
      default: return CFG_W'($urandom_range(8, 3));
    endcase
  endfunction

  function automatic void plan_cfg(logic [1:0] idx, logic [CFG_W-1:0] val);
    plan_entry_t e;
    e = '0;
    e.is_cfg = 1'b1;
    e.idx = idx;
    e.val = val;
    plan.push_back(e);
  endfunction

  // One image row of width three; the expectation, if any, sits on its last pixel.
  function automatic void plan_row(pix_in_t p, bit typed, pix_out_t want);
    plan_entry_t e;
    e = '0;
    e.p = p;
    plan.push_back(e);
    plan.push_back(e);
    e.typed = typed;
    e.want = want;
    plan.push_back(e);
  endfunction

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input pix_out_t got);
    pix_out_t want;
    if (filtered_due.size() == 0) begin
      $error("result transaction with nothing pending: %h", got);
      mismatches++;
    end else begin
      want = filtered_due.pop_front();
      compare_field("red_out", want.red_out, got.red_out);
      compare_field("green_out", want.green_out, got.green_out);
      compare_field("blue_out", want.blue_out, got.blue_out);
      compare_field("last_pixel", 8'(want.last_pixel), 8'(got.last_pixel));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) check_result(res);
      if (hold_left != 0) begin
        res_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!held_off && phase_num == PRESSURE_PHASE && res_valid) begin
        // Long hold-off so the output queue fills and the input backs up.
        res_stall <= 1'b1;
        hold_left <= HOLD_CYCLES;
        held_off <= 1'b1;
      end else begin
        res_stall <= ($urandom_range(99, 0) < dst_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pix_valid && !pix_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int      ph;
    int      count;
    pix_in_t hot;
    pix_in_t cold;
    for (int i = 0; i < LINE_MAX; i++) begin
      upper_row[i] = '0;
      middle_row[i] = '0;
    end
    for (int i = 0; i < 6; i++) window_col[i] = '0;

    hot = {8'hFF, 8'h00, 8'h55};
    cold = {8'h00, 8'hFF, 8'h55};
    // Width zero saturates to three; the mode stays at its reset value (blur)
    // for the first result. Mode changes mid-frame keep the frame going.
    plan_cfg(REG_WIDTH, '0);
    plan_cfg(REG_HEIGHT, CFG_W'(6));
    plan_cfg(REG_UNUSED, '1);
    plan_row(hot, 1'b0, '0);
    plan_row(hot, 1'b0, '0);
    plan_row(hot, 1'b1, {8'hFF, 8'h00, 8'h55, 1'b0});
    plan_cfg(REG_MODE, CFG_W'(MODE_SHARPEN));
    plan_row(cold, 1'b1, {8'hFF, 8'h00, 8'h55, 1'b0});
    plan_cfg(REG_MODE, CFG_W'(MODE_EDGE));
    plan_row(cold, 1'b1, {8'h00, 8'hFF, 8'h00, 1'b0});
    plan_cfg(REG_MODE, CFG_W'(MODE_PASS));
    plan_row(cold, 1'b1, {8'h00, 8'hFF, 8'h55, 1'b1});

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        push_pixel(plan[i].p, plan[i].typed, plan[i].want);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      src_idle_pct = (ph < 8) ? 27 : (ph < 16) ? 64 : 0;
      dst_idle_pct = (ph < 8) ? 64 : (ph < 16) ? 27 : 0;
      phase_num <= ph;
      settle();
      if (ph == WIDE_PHASE) begin
        // A longer line reaches line-memory entries that the small frames never touch.
        write_reg(REG_WIDTH, CFG_W'(LONG_WIDTH));
        write_reg(REG_HEIGHT, CFG_W'(3));
        count = 2 * LONG_WIDTH + 16;
      end else if (ph == PRESSURE_PHASE) begin
        write_reg(REG_WIDTH, CFG_W'(3));
        write_reg(REG_HEIGHT, CFG_W'(200));
        count = 150;
      end else begin
        if (ph == 0 || $urandom_range(2, 0) != 0) begin
          write_reg(REG_WIDTH, pick_width());
          write_reg(REG_HEIGHT, pick_height());
        end
        count = $urandom_range(44, 20);
      end
      write_reg(REG_MODE, CFG_W'($urandom_range(3, 0)));
      repeat (count) push_pixel({random_level(), random_level(), random_level()}, 1'b0, '0);
    end
    settle();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
